// File: sv/zcp_pkg.sv
// ----------------------------------------------------------------------------
// zcp_pkg
// Shared widths, constants, state codes and control structs for the
// zero-crossing pitch and RMS energy estimator.
// ----------------------------------------------------------------------------
package zcp_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int RATE_W     = 18;
   localparam int COUNT_W    = 20;
   localparam int SUM_W      = 50;
   localparam int SQ_W       = 32;
   localparam int PROD_W     = 41;
   localparam int ROOT_W     = 16;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int PITCH_W    = 13;
   localparam int ENERGY_W   = 14;
   localparam int CSR_IDX_W  = 1;

   localparam int CAPTURE_SECONDS_DEF = 3;

   localparam logic [RATE_W-1:0]   RATE_RESET    = RATE_W'(22050);
   localparam logic [COUNT_W-1:0]  MIN_SAMPLES   = COUNT_W'(512);
   localparam logic [COUNT_W-1:0]  MIN_CAP       = COUNT_W'(1024);
   localparam logic [COUNT_W-1:0]  COUNT_MAX     = {COUNT_W{1'b1}};
   localparam logic [ROOT_W-1:0]   ENERGY_LO     = ROOT_W'(983);
   localparam logic [ROOT_W-1:0]   ENERGY_HI     = ROOT_W'(11468);
   localparam logic [PITCH_W-1:0]  PITCH_LO      = PITCH_W'(1280);
   localparam logic [PITCH_W-1:0]  PITCH_HI      = PITCH_W'(5120);
   localparam logic [PITCH_W-1:0]  PITCH_DEFAULT = PITCH_W'(2240);
   localparam int                  SHORT_FACTOR  = 50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEREO_MODE = 1'b0,
      CSR_RATE_HZ     = 1'b1
   } csr_idx_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SETTLE = 6'b000010,
      ST_DIV_E  = 6'b000100,
      ST_SQRT   = 6'b001000,
      ST_DIV_P  = 6'b010000,
      ST_FIN    = 6'b100000
   } state_type;

   typedef enum logic {
      DIV_SRC_ENERGY = 1'b0,
      DIV_SRC_PITCH  = 1'b1
   } div_src_type;

   typedef struct packed {
      logic        take_item;
      logic        div_start;
      div_src_type div_src;
      logic        sqrt_start;
      logic        out_load;
      logic        clear;
   } cmd_type;

   typedef struct packed {
      logic last_item;
      logic too_short;
      logic div_busy;
      logic sqrt_busy;
      logic out_free;
   } stat_type;

endpackage

// File: sv/zcp_if.sv
// ----------------------------------------------------------------------------
// zcp_if
// Handshake channels of the estimator: input frames, results, register writes.
// ----------------------------------------------------------------------------
interface zcp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [zcp_pkg::SAMPLE_W-1:0]  left_sample;
   logic signed [zcp_pkg::SAMPLE_W-1:0]  right_sample;
   logic                                 last_frame;

   modport source (output valid, left_sample, right_sample, last_frame, input ready);
   modport sink   (input valid, left_sample, right_sample, last_frame, output ready);
endinterface

interface zcp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [zcp_pkg::PITCH_W-1:0]        pitch_q4;
   logic [zcp_pkg::ENERGY_W-1:0]       energy_q15;
   logic                               status;

   modport source (output valid, pitch_q4, energy_q15, status, input ready);
   modport sink   (input valid, pitch_q4, energy_q15, status, output ready);
endinterface

interface zcp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [zcp_pkg::CSR_IDX_W-1:0]      index;
   logic [zcp_pkg::RATE_W-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/zcp_ctrl.sv
// ----------------------------------------------------------------------------
// zcp_ctrl
// Sequencer: takes frames while idle, then, unless the capture is too short, runs
// energy divide, then square root beside pitch divide; hands result to output register.
// ----------------------------------------------------------------------------
module zcp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  zcp_pkg::stat_type stat,
   output zcp_pkg::cmd_type  cmd
);
   import zcp_pkg::*;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.div_src    = DIV_SRC_ENERGY;
      cmd.take_item  = req_valid && req_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take_item && stat.last_item) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            // last square lands in the sum at this edge; divider loads next sum
            if (stat.too_short) begin
               state_in = ST_FIN;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_E;
            end
         end
         ST_DIV_E: begin
            if (!stat.div_busy) begin
               cmd.sqrt_start = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.div_src    = DIV_SRC_PITCH;
               state_in       = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (!stat.sqrt_busy) begin
               state_in = ST_DIV_P;
            end
         end
         ST_DIV_P: begin
            if (!stat.div_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/zcp_dp.sv
// ----------------------------------------------------------------------------
// zcp_dp
// Datapath: config registers, per-frame accumulation, shared restoring
// divider, bit-pair square root and the result register.
// ----------------------------------------------------------------------------
module zcp_dp #(
   parameter int CAPTURE_SECONDS = zcp_pkg::CAPTURE_SECONDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   zcp_req_if.sink           req,
   zcp_rsp_if.source         rsp,
   zcp_csr_if.sink           csr,
   input  zcp_pkg::cmd_type  cmd,
   output zcp_pkg::stat_type stat
);
   import zcp_pkg::*;

   localparam int CS_W    = $clog2(CAPTURE_SECONDS + 1);
   localparam int CAP_W   = RATE_W + CS_W;
   localparam int DCNT_W  = $clog2(SUM_W);
   localparam int SCNT_W  = $clog2(ROOT_W);
   localparam int SHORT_W = COUNT_W + $clog2(SHORT_FACTOR + 1);

   // configuration
   logic              stereo_ff;
   logic [RATE_W-1:0] rate_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff <= 1'b0;
         rate_ff   <= RATE_RESET;
      end else if (csr.valid) begin
         unique case (csr_idx_type'(csr.index))
            CSR_STEREO_MODE: stereo_ff <= csr.data[0];
            CSR_RATE_HZ:     rate_ff   <= csr.data;
            default:         rate_ff   <= rate_ff;
         endcase
      end
   end

   // capture cap: CAPTURE_SECONDS * rate, clamped
   logic [CAP_W-1:0]   cap_raw;
   logic [COUNT_W-1:0] cap;

   assign cap_raw = CAP_W'(rate_ff) * CAP_W'(CAPTURE_SECONDS);

   always_comb begin
      if (cap_raw > CAP_W'(COUNT_MAX)) begin
         cap = COUNT_MAX;
      end else if (cap_raw < CAP_W'(MIN_CAP)) begin
         cap = MIN_CAP;
      end else begin
         cap = cap_raw[COUNT_W-1:0];
      end
   end

   // sample selection and squaring
   logic signed [SAMPLE_W:0]   pair_sum;
   logic signed [SAMPLE_W:0]   pair_adj;
   logic signed [SAMPLE_W-1:0] smp;
   logic [SAMPLE_W-1:0]        mag;
   logic                       take;
   logic                       crossing;
   logic signed [SAMPLE_W-1:0] prev_ff;
   logic [COUNT_W-1:0]         count_ff;
   logic [COUNT_W-1:0]         cross_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [SUM_W-1:0]           sum_in;
   logic [SQ_W-1:0]            sq_ff;
   logic                       take_ff;

   assign pair_sum = {req.left_sample[SAMPLE_W-1], req.left_sample}
                   + {req.right_sample[SAMPLE_W-1], req.right_sample};
   // round toward zero: bump negative sums before the shift
   assign pair_adj = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
   assign smp      = stereo_ff ? pair_adj[SAMPLE_W:1] : req.left_sample;
   assign mag      = smp[SAMPLE_W-1] ? (~smp + 1'b1) : smp;
   assign take     = (count_ff < cap);

   assign crossing = (count_ff != '0) &&
                     (((prev_ff[SAMPLE_W-1] || (prev_ff == '0)) &&
                       !smp[SAMPLE_W-1] && (smp != '0)) ||
                      (!prev_ff[SAMPLE_W-1] && smp[SAMPLE_W-1]));

   assign sum_in = sum_ff + (take_ff ? SUM_W'(sq_ff) : SUM_W'(0));

   always_ff @(posedge clock) begin
      sq_ff <= SQ_W'(mag) * SQ_W'(mag);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         take_ff  <= 1'b0;
         sum_ff   <= '0;
         count_ff <= '0;
         cross_ff <= '0;
         prev_ff  <= '0;
      end else begin
         take_ff <= cmd.take_item && take;
         sum_ff  <= sum_in;
         if (cmd.take_item && take) begin
            count_ff <= count_ff + 1'b1;
            prev_ff  <= smp;
            if (crossing) begin
               cross_ff <= cross_ff + 1'b1;
            end
         end
      end
   end

   // pitch numerator and short-capture flag, held stable while computing
   logic [PROD_W-1:0] prod_ff;
   logic              long_ff;
   logic [SHORT_W-1:0] count_x50;

   assign count_x50 = SHORT_W'(count_ff) * SHORT_W'(SHORT_FACTOR);

   always_ff @(posedge clock) begin
      prod_ff <= (PROD_W'(cross_ff) * PROD_W'(rate_ff)) << 3;
      long_ff <= count_x50 > SHORT_W'(rate_ff);
   end

   // shared restoring divider, one quotient bit a cycle
   logic [SUM_W-1:0]   quo_ff;
   logic [COUNT_W-1:0] rem_ff;
   logic [COUNT_W-1:0] dvs_ff;
   logic [DCNT_W-1:0]  dcnt_ff;
   logic               dbusy_ff;
   logic [COUNT_W:0]   dshift;
   logic               dfit;

   assign dshift = {rem_ff, quo_ff[SUM_W-1]};
   assign dfit   = dshift >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff  <= (cmd.div_src == DIV_SRC_PITCH) ? SUM_W'(prod_ff) : sum_in;
         rem_ff  <= '0;
         dvs_ff  <= count_ff;
         dcnt_ff <= '0;
      end else if (dbusy_ff) begin
         quo_ff  <= {quo_ff[SUM_W-2:0], dfit};
         rem_ff  <= dfit ? COUNT_W'(dshift - {1'b0, dvs_ff}) : dshift[COUNT_W-1:0];
         dcnt_ff <= dcnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
      end else if (dbusy_ff && (dcnt_ff == DCNT_W'(SUM_W - 1))) begin
         dbusy_ff <= 1'b0;
      end
   end

   // square root, one result bit a cycle
   logic [RAD_W-1:0]    rad_ff;
   logic [ROOT_W+1:0]   srem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [SCNT_W-1:0]   scnt_ff;
   logic                sbusy_ff;
   logic [ROOT_W+3:0]   strial;
   logic [ROOT_W+3:0]   sshift;
   logic                sfit;

   assign sshift = {srem_ff, rad_ff[RAD_W-1:RAD_W-2]};
   assign strial = {2'b00, root_ff, 2'b01};
   assign sfit   = sshift >= strial;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         rad_ff  <= quo_ff[RAD_W-1:0];
         srem_ff <= '0;
         root_ff <= '0;
         scnt_ff <= '0;
      end else if (sbusy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         srem_ff <= sfit ? (ROOT_W+2)'(sshift - strial) : sshift[ROOT_W+1:0];
         root_ff <= {root_ff[ROOT_W-2:0], sfit};
         scnt_ff <= scnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
      end else if (cmd.sqrt_start) begin
         sbusy_ff <= 1'b1;
      end else if (sbusy_ff && (scnt_ff == SCNT_W'(ROOT_W - 1))) begin
         sbusy_ff <= 1'b0;
      end
   end

   // result formatting and output register
   logic                short_cap;
   logic [PITCH_W-1:0]  pitch_val;
   logic [ROOT_W-1:0]   energy_val;
   logic                out_valid_ff;
   logic [PITCH_W-1:0]  pitch_ff;
   logic [ENERGY_W-1:0] energy_ff;
   logic                status_ff;

   assign short_cap = count_ff < MIN_SAMPLES;

   always_comb begin
      if (!long_ff) begin
         pitch_val = PITCH_DEFAULT;
      end else if (quo_ff < SUM_W'(PITCH_LO)) begin
         pitch_val = PITCH_LO;
      end else if (quo_ff > SUM_W'(PITCH_HI)) begin
         pitch_val = PITCH_HI;
      end else begin
         pitch_val = quo_ff[PITCH_W-1:0];
      end
      if (root_ff < ENERGY_LO) begin
         energy_val = ENERGY_LO;
      end else if (root_ff > ENERGY_HI) begin
         energy_val = ENERGY_HI;
      end else begin
         energy_val = root_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         status_ff <= short_cap;
         pitch_ff  <= short_cap ? '0 : pitch_val;
         energy_ff <= short_cap ? '0 : energy_val[ENERGY_W-1:0];
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.pitch_q4   = pitch_ff;
   assign rsp.energy_q15 = energy_ff;
   assign rsp.status     = status_ff;

   assign stat.last_item = req.last_frame;
   assign stat.too_short = short_cap;
   assign stat.div_busy  = dbusy_ff;
   assign stat.sqrt_busy = sbusy_ff;
   assign stat.out_free  = !out_valid_ff || rsp.ready;

endmodule

// File: sv/zero_crossing_pitch_rms_estimator.sv
// ----------------------------------------------------------------------------
// zero_crossing_pitch_rms_estimator
// Estimates pitch from zero crossings and RMS energy over one audio capture.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one PCM frame per item (left, right, last_frame). While no
//   capture is being finished, ready stays high and a frame is taken every
//   cycle. The frame with last_frame set closes the capture. After it is
//   taken, the shared 50-step restoring divider runs twice (energy mean,
//   then pitch ratio), a 16-step square root runs beside the second
//   divide, and the result appears on rsp. A capture under 512 samples
//   skips the arithmetic and reports status 1.
//   csr writes stereo_mode (index 0) and the rate in Hz (index 1); it is
//   always ready. Write it only between captures.
//   Reset restores mono mode, a 22050 Hz rate and clears the capture.
//   The result waits in an output register: new frames are taken while it is
//   pending, but a following capture end holds until rsp accepts it.
// ----------------------------------------------------------------------------
module zero_crossing_pitch_rms_estimator #(
   parameter int CAPTURE_SECONDS = zcp_pkg::CAPTURE_SECONDS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   zcp_req_if.sink   req,
   zcp_rsp_if.source rsp,
   zcp_csr_if.sink   csr
);
   import zcp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: owns req.ready and orders the divide / root passes
   zcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // accumulators, arithmetic units, config and result register
   zcp_dp #(
      .CAPTURE_SECONDS (CAPTURE_SECONDS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule
